### hw/rtl/gqi_pkg.sv
// Shared types, constants and small tables for the gyro quaternion integrator.
package gqi_pkg;

  localparam int QUAT_W = 32;
  localparam int RATE_W = 16;
  localparam int DT_W   = 16;
  localparam int TILT_W = 16;

  // Shared multiplier: signed A times signed B, B taken in two halves.
  localparam int MA_W   = 37;
  localparam int MB_W   = 36;
  localparam int MP_W   = MA_W + MB_W;
  localparam int BL_W   = 18;
  localparam int P32_W  = MP_W - 32;
  localparam int P36_W  = MP_W - 36;

  localparam int H_W    = 35;
  localparam int N_W    = MA_W;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 34;
  localparam int S_W    = 29;
  localparam int R_W    = 31;
  localparam int CX_W   = 36;
  localparam int ANG_W  = 26;
  localparam int TAB_W  = 22;
  localparam int OP_W   = 6;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 5;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 34;
  localparam int CORD_STEPS = 20;
  localparam int ANG_SHIFT  = 8;

  localparam logic signed [MB_W-1:0]   RAD_K    = 36'sd10061138136;
  localparam logic signed [H_W-1:0]    H_LIM    = 35'sh3FFFFFFFF;
  localparam logic signed [N_W-1:0]    V_LIM    = 37'sh07FFFFFFF;
  localparam logic signed [QUAT_W-1:0] V_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [QUAT_W-1:0] V_MIN    = 32'sh80000001;
  localparam logic signed [QUAT_W-1:0] Q_ONE    = 32'sh40000000;
  localparam logic [ROOT_W-1:0]        SAT_NORM = 34'd67108864;
  localparam logic signed [R_W-1:0]    R33_ONE  = 31'sd16777216;
  localparam logic signed [ANG_W-1:0]  ANG_90   = 26'sd5898240;
  localparam logic signed [ANG_W-1:0]  ANG_HALF = 26'sd128;
  localparam logic [TILT_W-1:0]        TILT_MAX = 16'd46080;

  localparam logic [OP_W-1:0] OP_H0   = 6'd0;
  localparam logic [OP_W-1:0] OP_T0   = 6'd6;
  localparam logic [OP_W-1:0] OP_SQ0  = 6'd18;
  localparam logic [OP_W-1:0] OP_SQL  = 6'd21;
  localparam logic [OP_W-1:0] OP_NM0  = 6'd22;
  localparam logic [OP_W-1:0] OP_NML  = 6'd25;
  localparam logic [OP_W-1:0] OP_TL0  = 6'd26;
  localparam logic [OP_W-1:0] OP_RS0  = 6'd32;
  localparam logic [OP_W-1:0] OP_LAST = 6'd33;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MGO, ST_MWAIT, ST_RGO, ST_RWAIT, ST_DGO, ST_DWAIT,
    ST_COMMIT, ST_TGO, ST_TWAIT, ST_CGO, ST_CWAIT, ST_OUT
  } gqi_state_t;

  typedef enum logic [2:0] {
    GRP_RATE, GRP_TERM, GRP_SQ, GRP_NORM, GRP_TILT, GRP_RSQ
  } op_grp_t;

  typedef enum logic {ITER_SQRT, ITER_DIV} iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic [1:0] comp;
    logic [1:0] qi;
    logic [1:0] hi;
    logic       neg;
  } term_sel_t;

  typedef struct packed {
    logic [1:0] qa;
    logic [1:0] qb;
    logic [1:0] dst;
    logic       neg;
  } tilt_sel_t;

  // Quaternion product q * (0, h): component, q index, h index, subtract.
  function automatic term_sel_t term_sel(input logic [3:0] t);
    term_sel_t s;
    s = '0;
    case (t)
      4'd0:    s = '{2'd0, 2'd1, 2'd0, 1'b1};
      4'd1:    s = '{2'd0, 2'd2, 2'd1, 1'b1};
      4'd2:    s = '{2'd0, 2'd3, 2'd2, 1'b1};
      4'd3:    s = '{2'd1, 2'd0, 2'd0, 1'b0};
      4'd4:    s = '{2'd1, 2'd2, 2'd2, 1'b0};
      4'd5:    s = '{2'd1, 2'd3, 2'd1, 1'b1};
      4'd6:    s = '{2'd2, 2'd0, 2'd1, 1'b0};
      4'd7:    s = '{2'd2, 2'd1, 2'd2, 1'b1};
      4'd8:    s = '{2'd2, 2'd3, 2'd0, 1'b0};
      4'd9:    s = '{2'd3, 2'd0, 2'd2, 1'b0};
      4'd10:   s = '{2'd3, 2'd1, 2'd1, 1'b0};
      4'd11:   s = '{2'd3, 2'd2, 2'd0, 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Rotation matrix terms: xz, yw into r13; yz, -xw into r23; xx, yy into r33.
  function automatic tilt_sel_t tilt_sel(input logic [2:0] t);
    tilt_sel_t s;
    s = '0;
    case (t)
      3'd0:    s = '{2'd1, 2'd3, 2'd0, 1'b0};
      3'd1:    s = '{2'd2, 2'd0, 2'd0, 1'b0};
      3'd2:    s = '{2'd2, 2'd3, 2'd1, 1'b0};
      3'd3:    s = '{2'd1, 2'd0, 2'd1, 1'b1};
      3'd4:    s = '{2'd1, 2'd1, 2'd2, 1'b0};
      3'd5:    s = '{2'd2, 2'd2, 2'd2, 1'b0};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [TAB_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [TAB_W-1:0] v;
    v = '0;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [H_W-1:0] h_clamp(input logic signed [P32_W-1:0] p);
    logic signed [P32_W-1:0] lim;
    lim = P32_W'(H_LIM);
    if (p > lim) return H_LIM;
    else if (p < -lim) return -H_LIM;
    else return p[H_W-1:0];
  endfunction

  // Integrated component taken to Q.28 and limited to a symmetric 32-bit range.
  function automatic logic signed [QUAT_W-1:0] v_clamp(input logic signed [N_W-1:0] n);
    logic signed [N_W-1:0] s;
    s = n >>> 2;
    if (s > V_LIM) return V_MAX;
    else if (s < -V_LIM) return V_MIN;
    else return s[QUAT_W-1:0];
  endfunction

endpackage

### hw/rtl/gqi_in_if.sv
// Input channel: gyro rates and time step with valid/ready handshake.
interface gqi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gqi_pkg::RATE_W-1:0]      gyro_x;
  logic signed [gqi_pkg::RATE_W-1:0]      gyro_y;
  logic signed [gqi_pkg::RATE_W-1:0]      gyro_z;
  logic        [gqi_pkg::DT_W-1:0]        time_step;

  modport source (output valid, gyro_x, gyro_y, gyro_z, time_step, input ready);
  modport sink   (input valid, gyro_x, gyro_y, gyro_z, time_step, output ready);
endinterface

### hw/rtl/gqi_out_if.sv
// Result channel: updated quaternion and tilt angle with valid/ready handshake.
interface gqi_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gqi_pkg::QUAT_W-1:0]      quat_w;
  logic signed [gqi_pkg::QUAT_W-1:0]      quat_x;
  logic signed [gqi_pkg::QUAT_W-1:0]      quat_y;
  logic signed [gqi_pkg::QUAT_W-1:0]      quat_z;
  logic        [gqi_pkg::TILT_W-1:0]      tilt_angle;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, tilt_angle, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, tilt_angle, output ready);
endinterface

### hw/rtl/gqi_mul.sv
// Shared signed multiplier, operand B split into two halves.
module gqi_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gqi_pkg::MA_W-1:0]   a,
  input  logic signed [gqi_pkg::MB_W-1:0]   b,
  output logic signed [gqi_pkg::MP_W-1:0]   prod,
  output logic                              done
);
  import gqi_pkg::*;

  logic signed [MA_W-1:0]       a_r;
  logic signed [MB_W-BL_W-1:0]  bh_r;
  logic signed [MA_W+BL_W:0]    lo_r;
  logic signed [MA_W+BL_W:0]    lo_nxt;
  logic signed [MP_W-1:0]       hi_full;
  logic signed [MP_W-1:0]       lo_full;
  logic signed [MP_W-1:0]       prod_r;
  logic                         busy_r;
  logic                         done_r;

  always_comb begin
    lo_nxt  = a * $signed({1'b0, b[BL_W-1:0]});
    hi_full = a_r * bh_r;
    lo_full = lo_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      bh_r <= b[MB_W-1:BL_W];
      lo_r <= lo_nxt;
    end
    if (busy_r) begin
      prod_r <= (hi_full <<< BL_W) + lo_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  assign prod = prod_r;
  assign done = done_r;
endmodule

### hw/rtl/gqi_iter.sv
// Iterative square root and reciprocal unit sharing one subtract and compare.
module gqi_iter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gqi_pkg::iter_ctl_t                ctl,
  input  logic [gqi_pkg::SUM_W-1:0]         opnd,
  output logic [gqi_pkg::ROOT_W-1:0]        res,
  output logic                              done
);
  import gqi_pkg::*;

  logic              busy_r;
  logic              done_r;
  iter_mode_t        mode_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  v_r;
  logic [SUM_W-1:0]  r_r;
  logic [ROOT_W-1:0] quo_r;
  logic [SUM_W-1:0]  bitv;
  logic [SUM_W-1:0]  minu;
  logic [SUM_W-1:0]  subt;
  logic [SUM_W:0]    diff;
  logic              ge;

  // Square root: v against r + bit. Reciprocal: shifted remainder against divisor.
  always_comb begin
    bitv = SUM_W'(1) << {cnt_r[STEP_W-1:0], 1'b0};
    if (mode_r == ITER_SQRT) begin
      minu = v_r;
      subt = r_r + bitv;
    end else begin
      minu = {v_r[SUM_W-2:0], 1'b0};
      subt = r_r;
    end
    diff = {1'b0, minu} - {1'b0, subt};
    ge   = ~diff[SUM_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      if (ctl.mode == ITER_SQRT) begin
        v_r   <= opnd;
        r_r   <= '0;
        cnt_r <= CNT_W'(SQRT_STEPS - 1);
      end else begin
        // The numerator is 2^60; its top part 2^26 is known to be below the divisor.
        v_r   <= SUM_W'(SAT_NORM);
        r_r   <= opnd;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end
      quo_r <= '0;
    end else if (busy_r) begin
      if (mode_r == ITER_SQRT) begin
        if (ge) begin
          v_r <= diff[SUM_W-1:0];
          r_r <= (r_r >> 1) + bitv;
        end else begin
          r_r <= r_r >> 1;
        end
      end else begin
        v_r   <= ge ? diff[SUM_W-1:0] : minu;
        quo_r <= {quo_r[ROOT_W-2:0], ge};
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= ITER_SQRT;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        mode_r <= ctl.mode;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign res  = (mode_r == ITER_SQRT) ? r_r[ROOT_W-1:0] : quo_r;
  assign done = done_r;
endmodule

### hw/rtl/gqi_cordic.sv
// Vectoring CORDIC that returns the angle of (cx, cy) in 1/256 degree.
module gqi_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gqi_pkg::R_W-1:0]    cx0,
  input  logic [gqi_pkg::ROOT_W-2:0]        cy0,
  output logic [gqi_pkg::TILT_W-1:0]        angle,
  output logic                              done
);
  import gqi_pkg::*;

  logic signed [CX_W-1:0]  cx_r;
  logic signed [CX_W-1:0]  cy_r;
  logic signed [ANG_W-1:0] ang_r;
  logic [STEP_W-1:0]       i_r;
  logic                    busy_r;
  logic                    done_r;
  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [ANG_W-1:0] at;
  logic signed [CX_W-1:0]  cy_ext;
  logic signed [ANG_W-1:0] ang_pos;
  logic signed [ANG_W-1:0] ang_rnd;

  always_comb begin
    xs      = cx_r >>> i_r;
    ys      = cy_r >>> i_r;
    at      = ANG_W'($signed({1'b0, atan_step(i_r)}));
    cy_ext  = CX_W'($signed({1'b0, cy0}));
    ang_pos = (ang_r < 0) ? '0 : ang_r;
    ang_rnd = (ang_pos + ANG_HALF) >>> ANG_SHIFT;
    if (ang_rnd > ANG_W'(TILT_MAX)) angle = TILT_MAX;
    else angle = ang_rnd[TILT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // A vector in the left half plane is first turned by ninety degrees.
      if (cx0 < 0) begin
        cx_r  <= cy_ext;
        cy_r  <= -CX_W'(cx0);
        ang_r <= ANG_90;
      end else begin
        cx_r  <= CX_W'(cx0);
        cy_r  <= cy_ext;
        ang_r <= '0;
      end
      i_r <= '0;
    end else if (busy_r) begin
      if (cy_r > 0) begin
        cx_r  <= cx_r + ys;
        cy_r  <= cy_r - xs;
        ang_r <= ang_r + at;
      end else if (cy_r < 0) begin
        cx_r  <= cx_r - ys;
        cy_r  <= cy_r + xs;
        ang_r <= ang_r - at;
      end
      i_r <= i_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == STEP_W'(CORD_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
endmodule

### hw/rtl/gyro_quaternion_integrator_unit.sv
// Top level: sequencer and datapath of the gyro quaternion integrator.
//
//   channel   direction  handshake          word
//   in_ch     sink       valid/ready        gyro_x, gyro_y, gyro_z, time_step
//   out_ch    source     valid/ready        quat_w, quat_x, quat_y, quat_z, tilt_angle
//
// One word runs 34 passes of the shared multiplier, two 32-step square roots, the 34-step
// reciprocal and the 20-step CORDIC. A small norm saturates the reciprocal and skips the
// division; a zero integrated quaternion skips the first square root, the reciprocal and
// the four normalising passes. The input is ready only while the sequencer is idle;
// a finished word waits in the output register, so the next input is taken while it is pending.
// Reset is synchronous and sets the attitude to the identity quaternion.
module gyro_quaternion_integrator_unit (
  input  logic   clk,
  input  logic   rst_n,
  gqi_in_if.sink   in_ch,
  gqi_out_if.source out_ch
);
  import gqi_pkg::*;

  gqi_state_t state_r, state_nxt;

  logic signed [QUAT_W-1:0] q_r [4];
  logic signed [N_W-1:0]    n_r [4];
  logic signed [RATE_W-1:0] g_r [3];
  logic signed [H_W-1:0]    h_r [3];
  logic [DT_W-1:0]          dt_r;
  logic signed [QUAT_W-1:0] tmp_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W-1:0]        inv_r;
  logic signed [S_W-1:0]    s13_r, s23_r, s33_r;
  logic [OP_W-1:0]          op_r;

  logic signed [QUAT_W-1:0] oq_r [4];
  logic [TILT_W-1:0]        otilt_r;
  logic                     out_valid_r;

  op_grp_t                  grp;
  logic [OP_W-1:0]          rel;
  term_sel_t                ts;
  tilt_sel_t                ls;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [MP_W-1:0]   mul_prod;
  logic                     mul_start, mul_done;
  logic signed [P32_W-1:0]  p32;
  logic signed [P36_W-1:0]  p36;
  logic [SUM_W-1:0]         sum_add;
  logic signed [S_W:0]      r13, r23;
  logic signed [R_W-1:0]    r33;
  iter_ctl_t                ictl;
  logic [SUM_W-1:0]         iopnd;
  logic [ROOT_W-1:0]        root_res;
  logic                     iter_done;
  logic                     cord_start, cord_done;
  logic [TILT_W-1:0]        cord_angle;
  logic                     in_acc, out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // Operation decode and multiplier operand selection.
  always_comb begin
    if (op_r < OP_T0) begin
      grp = GRP_RATE;  rel = op_r - OP_H0;
    end else if (op_r < OP_SQ0) begin
      grp = GRP_TERM;  rel = op_r - OP_T0;
    end else if (op_r < OP_NM0) begin
      grp = GRP_SQ;    rel = op_r - OP_SQ0;
    end else if (op_r < OP_TL0) begin
      grp = GRP_NORM;  rel = op_r - OP_NM0;
    end else if (op_r < OP_RS0) begin
      grp = GRP_TILT;  rel = op_r - OP_TL0;
    end else begin
      grp = GRP_RSQ;   rel = op_r - OP_RS0;
    end
    ts  = term_sel(rel[3:0]);
    ls  = tilt_sel(rel[2:0]);
    r13 = {s13_r, 1'b0};
    r23 = {s23_r, 1'b0};
    r33 = R33_ONE - (R_W'(s33_r) <<< 1);
    ma  = '0;
    mb  = '0;
    case (grp)
      GRP_RATE: begin
        // Even step forms rate times dt, odd step scales it to radians.
        if (!rel[0]) begin
          ma = MA_W'(g_r[rel[2:1]]);
          mb = MB_W'($signed({1'b0, dt_r}));
        end else begin
          ma = MA_W'(tmp_r);
          mb = RAD_K;
        end
      end
      GRP_TERM: begin
        ma = MA_W'(q_r[ts.qi]);
        mb = MB_W'(h_r[ts.hi]);
      end
      GRP_SQ: begin
        ma = MA_W'(v_clamp(n_r[rel[1:0]]));
        mb = MB_W'(v_clamp(n_r[rel[1:0]]));
      end
      GRP_NORM: begin
        ma = n_r[rel[1:0]];
        mb = MB_W'($signed({1'b0, inv_r}));
      end
      GRP_TILT: begin
        ma = MA_W'(q_r[ls.qa]);
        mb = MB_W'(q_r[ls.qb]);
      end
      GRP_RSQ: begin
        ma = (rel[0]) ? MA_W'(r23) : MA_W'(r13);
        mb = (rel[0]) ? MB_W'(r23) : MB_W'(r13);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    p32     = $signed(mul_prod[MP_W-1:32]);
    p36     = $signed(mul_prod[MP_W-1:36]);
    sum_add = sum_r + mul_prod[SUM_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    cord_start = 1'b0;
    ictl       = '{start: 1'b0, mode: ITER_SQRT};
    iopnd      = sum_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_MGO;
      ST_MGO: begin
        mul_start = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          if (op_r == OP_SQL) state_nxt = (sum_add == '0) ? ST_COMMIT : ST_RGO;
          else if (op_r == OP_NML) state_nxt = ST_COMMIT;
          else if (op_r == OP_LAST) state_nxt = ST_TGO;
          else state_nxt = ST_MGO;
        end
      end
      ST_RGO: begin
        ictl      = '{start: 1'b1, mode: ITER_SQRT};
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        // A small norm saturates the reciprocal, so the division is skipped.
        if (iter_done) state_nxt = (root_res <= SAT_NORM) ? ST_MGO : ST_DGO;
      end
      ST_DGO: begin
        ictl      = '{start: 1'b1, mode: ITER_DIV};
        iopnd     = SUM_W'(root_res);
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT:  if (iter_done) state_nxt = ST_MGO;
      ST_COMMIT: state_nxt = ST_MGO;
      ST_TGO: begin
        ictl      = '{start: 1'b1, mode: ITER_SQRT};
        state_nxt = ST_TWAIT;
      end
      ST_TWAIT:  if (iter_done) state_nxt = ST_CGO;
      ST_CGO: begin
        cord_start = 1'b1;
        state_nxt  = ST_CWAIT;
      end
      ST_CWAIT:  if (cord_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      g_r[0] <= in_ch.gyro_x;
      g_r[1] <= in_ch.gyro_y;
      g_r[2] <= in_ch.gyro_z;
      dt_r   <= in_ch.time_step;
      for (int i = 0; i < 4; i++) n_r[i] <= N_W'(q_r[i]);
      sum_r  <= '0;
      op_r   <= OP_H0;
    end
    if (state_r == ST_MWAIT && mul_done) begin
      op_r <= op_r + OP_W'(1);
      case (grp)
        GRP_RATE: begin
          if (!rel[0]) tmp_r <= mul_prod[QUAT_W-1:0];
          else h_r[rel[2:1]] <= h_clamp(p32);
        end
        GRP_TERM: begin
          if (ts.neg) n_r[ts.comp] <= n_r[ts.comp] - N_W'(p32);
          else n_r[ts.comp] <= n_r[ts.comp] + N_W'(p32);
        end
        GRP_SQ:   sum_r <= sum_add;
        GRP_NORM: n_r[rel[1:0]] <= N_W'(p32);
        GRP_TILT: begin
          if (ls.dst == 2'd0) s13_r <= s13_r + S_W'(p36);
          else if (ls.dst == 2'd1) begin
            if (ls.neg) s23_r <= s23_r - S_W'(p36);
            else s23_r <= s23_r + S_W'(p36);
          end else s33_r <= s33_r + S_W'(p36);
        end
        GRP_RSQ:  sum_r <= sum_add;
        default:  tmp_r <= tmp_r;
      endcase
    end
    if (state_r == ST_RWAIT && iter_done && root_res <= SAT_NORM) begin
      inv_r <= H_LIM[ROOT_W-1:0];
    end
    if (state_r == ST_DWAIT && iter_done) begin
      inv_r <= root_res;
    end
    if (state_r == ST_COMMIT) begin
      sum_r <= '0;
      s13_r <= '0;
      s23_r <= '0;
      s33_r <= '0;
      op_r  <= OP_TL0;
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) oq_r[i] <= q_r[i];
      otilt_r <= cord_angle;
    end
  end

  // Attitude state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0]      <= Q_ONE;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_COMMIT) begin
        for (int i = 0; i < 4; i++) q_r[i] <= n_r[i][QUAT_W-1:0];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  gqi_mul u_gqi_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  gqi_iter u_gqi_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ictl),
    .opnd  (iopnd),
    .res   (root_res),
    .done  (iter_done)
  );

  gqi_cordic u_gqi_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .cx0   (r33),
    .cy0   (root_res[ROOT_W-2:0]),
    .angle (cord_angle),
    .done  (cord_done)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.quat_w     = oq_r[0];
  assign out_ch.quat_x     = oq_r[1];
  assign out_ch.quat_y     = oq_r[2];
  assign out_ch.quat_z     = oq_r[3];
  assign out_ch.tilt_angle = otilt_r;
endmodule

### hw/rtl/gqi_checker.sv
// Port-level checker for the gyro quaternion integrator and its bind statement.
module gqi_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [gqi_pkg::QUAT_W-1:0] quat_w,
  input logic [gqi_pkg::TILT_W-1:0]        tilt_angle
);
  import gqi_pkg::*;

  // The block works on one word at a time, so it drops ready after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after a word was taken");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tilt_angle <= TILT_MAX))
    else $error("tilt angle above 180 degrees");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(quat_w) && $stable(tilt_angle)))
    else $error("stalled result word changed");

endmodule

bind gyro_quaternion_integrator_unit gqi_checker u_gqi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .quat_w     (out_ch.quat_w),
  .tilt_angle (out_ch.tilt_angle)
);
